/* rtl/uhsp_pkg.sv */
// Package for the URL hash block: hash constants, payload and state types.
// No dependencies; used by the interfaces, uhsp_mix and the top level.
package uhsp_pkg;

	localparam int unsigned HashW   = 32;
	localparam int unsigned PrefixW = 16;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned ResultW = PrefixW + HashW;

	localparam logic [HashW-1:0] HashMult  = 32'h9E37_79B9;
	localparam logic [ByteW-1:0] ColonCode = 8'h3A;
	localparam int unsigned      RotLeft   = 5;

	// running state of one URL
	typedef struct packed {
		logic [HashW-1:0]   hash;
		logic [PrefixW-1:0] prefix;
		logic               colon_seen;
	} hash_state_t;

endpackage

/* rtl/uhsp_in_if.sv */
// Input stream interface: one URL byte per beat plus byte and end marks.
// Depends on uhsp_pkg for widths.
interface uhsp_in_if;
	logic                           valid;
	logic                           ready;
	logic [uhsp_pkg::ByteW-1:0]     data_byte;
	logic                           has_byte;
	logic                           last_byte;

	modport source (output valid, output data_byte, output has_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input last_byte,
		output ready);
endinterface

/* rtl/uhsp_out_if.sv */
// Output stream interface: one 48-bit hash word per beat.
// Depends on uhsp_pkg for widths.
interface uhsp_out_if;
	logic                           valid;
	logic                           ready;
	logic [uhsp_pkg::ResultW-1:0]   hash_word;

	modport source (output valid, output hash_word, input ready);
	modport sink (input valid, input hash_word, output ready);
endinterface

/* rtl/uhsp_mix.sv */
// One hash step: rotate left, xor byte, multiply by golden-ratio constant;
// captures the prefix at the first colon. Depends on uhsp_pkg.
module uhsp_mix (
	input  uhsp_pkg::hash_state_t          cur,
	input  logic [uhsp_pkg::ByteW-1:0]     data_byte,
	input  logic                           has_byte,
	output uhsp_pkg::hash_state_t          nxt
);

	logic [uhsp_pkg::HashW-1:0] rot;
	logic [uhsp_pkg::HashW-1:0] mixed;
	logic [uhsp_pkg::HashW-1:0] prod;
	logic                       first_colon;

	assign rot   = {cur.hash[uhsp_pkg::HashW-uhsp_pkg::RotLeft-1:0],
		cur.hash[uhsp_pkg::HashW-1 -: uhsp_pkg::RotLeft]};
	assign mixed = rot ^ {{(uhsp_pkg::HashW-uhsp_pkg::ByteW){1'b0}}, data_byte};
	// product kept modulo 2^32
	assign prod  = mixed * uhsp_pkg::HashMult;

	assign first_colon = has_byte && !cur.colon_seen && (data_byte == uhsp_pkg::ColonCode);

	always_comb begin
		nxt = cur;
		if (has_byte) begin
			nxt.hash = prod;
		end
		if (first_colon) begin
			// prefix is the low PrefixW bits of the hash of the bytes before the colon
			nxt.prefix     = cur.hash[uhsp_pkg::PrefixW-1:0];
			nxt.colon_seen = 1'b1;
		end
	end

endmodule

/* rtl/url_hash_with_scheme_prefix_core.sv */
// URL hash with scheme prefix, top level.
// The result is registered when the last-marked beat leaves the input stage.
// Throughput: 1 byte per cycle, less when a last beat waits on the output register;
// the hash step (rotate, xor, constant 32x32 multiply) from s1 to state_q sets it.
// Reset (arst_n low, asynchronous): hash state, stage and output valids clear.
// Depends on uhsp_pkg, uhsp_in_if, uhsp_out_if, uhsp_mix.
module url_hash_with_scheme_prefix_core (
	input  logic              clk,
	input  logic              arst_n,
	uhsp_in_if.sink           item,
	uhsp_out_if.source        result
);

	// input stage
	logic                           valid_s1;
	logic [uhsp_pkg::ByteW-1:0]     data_byte_s1;
	logic                           has_byte_s1;
	logic                           last_byte_s1;

	// running state and output register
	uhsp_pkg::hash_state_t          state_q;
	uhsp_pkg::hash_state_t          state_nxt;
	logic                           out_valid_q;
	logic [uhsp_pkg::ResultW-1:0]   hash_word_q;

	logic                           advance;
	logic                           in_take;

	// A non-last beat only updates state and always moves on; a last beat
	// needs the output register free (or being drained this cycle).
	assign advance = valid_s1 && (!last_byte_s1 || !out_valid_q || result.ready);
	assign in_take = item.valid && item.ready;

	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_byte_s1 <= item.data_byte;
			has_byte_s1  <= item.has_byte;
			last_byte_s1 <= item.last_byte;
		end
	end

	uhsp_mix u_mix (
		.cur       (state_q),
		.data_byte (data_byte_s1),
		.has_byte  (has_byte_s1),
		.nxt       (state_nxt)
	);

	// state returns to reset after the last beat of a URL
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			if (last_byte_s1) begin
				state_q <= '0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_byte_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// prefix field is zero when no colon was seen
	always_ff @(posedge clk) begin
		if (advance && last_byte_s1) begin
			hash_word_q <= {(state_nxt.colon_seen ? state_nxt.prefix : {uhsp_pkg::PrefixW{1'b0}}),
				state_nxt.hash};
		end
	end

	assign result.valid     = out_valid_q;
	assign result.hash_word = hash_word_q;

endmodule
